>>> hw/rtl/fqo_pkg.sv
`default_nettype none

package fqo_pkg;

   // configuration port geometry
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // coefficient and report formats (Q1.15)
   localparam int COEF_W    = 16;
   localparam int OUT_W     = 16;
   localparam int OUT_LANES = 4;

   // lanes that own a coefficient pair in the register map
   localparam int CSR_LANES = 4;

   // low index bit picks cosine or sine of a lane
   localparam logic CSR_SEL_COS = 1'b0;
   localparam logic CSR_SEL_SIN = 1'b1;

   localparam logic signed [COEF_W-1:0] COEF_COS_RESET = 16'sh7fff;
   localparam logic signed [COEF_W-1:0] COEF_SIN_RESET = 16'sh0000;

   // rotation coefficient pair of one lane
   typedef struct packed {
      logic signed [COEF_W-1:0] cos_v;
      logic signed [COEF_W-1:0] sin_v;
   } coef_type;

endpackage

`default_nettype wire

>>> hw/rtl/four_lane_quadrature_oscillator.sv
`default_nettype none

// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_advance
// rsp       out        rsp_valid/rsp_stall  rsp_lane0_out .. rsp_lane3_out
// csr       in         csr_write            csr_index, csr_data
//
// A report-only transaction leaves the lanes idle; one that advances the phasors
// stalls the next transaction while the one multiplier of each lane
// forms all eight products of a rotation and renormalization in turn.
// The report is registered at acceptance and waits for the consumer while the
// lanes run. Reset is synchronous: phasors return to (max, 0), coefficients to
// (max, 0), and the output register empties.

module four_lane_quadrature_oscillator
   import fqo_pkg::*;
#(
   parameter int LANES        = 4,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic                     req_advance,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic signed [OUT_W-1:0]  rsp_lane0_out,
   output      logic signed [OUT_W-1:0]  rsp_lane1_out,
   output      logic signed [OUT_W-1:0]  rsp_lane2_out,
   output      logic signed [OUT_W-1:0]  rsp_lane3_out,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data
);

   coef_type                            lane_coef [LANES];
   logic [LANES-1:0]                    lane_busy;
   logic [LANES-1:0][SAMPLE_WIDTH-1:0]  lane_imag;
   logic [OUT_LANES-1:0][OUT_W-1:0]     rsp_data;
   logic                                accept;

   // coefficient registers, lanes beyond the map keep reset values
   for (genvar k = 0; k < LANES; k++) begin : g_coef
      if (k < CSR_LANES) begin : g_reg
         localparam logic [CSR_IDX_W-2:0] LANE_ID = (CSR_IDX_W - 1)'(k);
         coef_type coef_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               coef_ff.cos_v <= COEF_COS_RESET;
               coef_ff.sin_v <= COEF_SIN_RESET;
            end else if (csr_write && (csr_index[CSR_IDX_W-1:1] == LANE_ID)) begin
               if (csr_index[0] == CSR_SEL_SIN) begin
                  coef_ff.sin_v <= $signed(csr_data);
               end else begin
                  coef_ff.cos_v <= $signed(csr_data);
               end
            end
         end
         assign lane_coef[k] = coef_ff;
      end else begin : g_const
         assign lane_coef[k] = '{cos_v: COEF_COS_RESET, sin_v: COEF_SIN_RESET};
      end
   end

   // transaction acceptance: lanes settled and output slot free
   assign req_stall = (|lane_busy) || (rsp_valid && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // oscillator lanes
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      fqo_lane #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .start (accept && req_advance),
         .coef  (lane_coef[k]),
         .busy  (lane_busy[k]),
         .imag  (lane_imag[k])
      );
   end

   // collect lane reports into the response register
   fqo_merge #(
      .LANES        (LANES),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .capture   (accept),
      .lane_imag (lane_imag),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_lane0_out = $signed(rsp_data[0]);
   assign rsp_lane1_out = $signed(rsp_data[1]);
   assign rsp_lane2_out = $signed(rsp_data[2]);
   assign rsp_lane3_out = $signed(rsp_data[3]);

endmodule

`default_nettype wire

>>> hw/rtl/fqo_lane.sv
`default_nettype none

module fqo_lane
   import fqo_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire coef_type                       coef,
   output      logic                           busy,
   output      logic signed [SAMPLE_WIDTH-1:0] imag
);

   localparam int W   = SAMPLE_WIDTH;
   localparam int FS  = W - 1;
   localparam int OPW = (W + 1 > COEF_W) ? W + 1 : COEF_W;
   localparam int PW  = 2 * OPW;

   localparam logic signed [PW-1:0] WIDE_HI    = $signed((PW'(1) << W) - PW'(1));
   localparam logic signed [PW-1:0] WIDE_LO    = -WIDE_HI;
   localparam logic signed [PW-1:0] SMP_HI     = $signed((PW'(1) << FS) - PW'(1));
   localparam logic signed [PW-1:0] SMP_LO     = -$signed(PW'(1) << FS);
   localparam logic signed [PW-1:0] THREE_HALF = $signed(PW'(3) << (FS - 1));

   typedef enum logic [3:0] {
      ST_IDLE, ST_RC, ST_IS, ST_RS, ST_IC, ST_RR, ST_IR,
      ST_II, ST_L, ST_F, ST_FR, ST_FI, ST_WI
   } state_type;

   state_type state_ff, state_in;

   logic signed [PW-1:0]  p_ff, p_in;
   logic signed [PW-1:0]  acc_ff, acc_in;
   logic signed [W:0]     r_ff, r_in;
   logic signed [W:0]     i_ff, i_in;
   logic signed [W:0]     f_ff, f_in;
   logic signed [W-1:0]   re_ff, re_in;
   logic signed [W-1:0]   im_ff, im_in;

   logic signed [OPW-1:0] mul_a;
   logic signed [OPW-1:0] mul_b;
   logic signed [PW-1:0]  prod;

   // round half away from zero, then drop sh fraction bits
   function automatic logic signed [PW-1:0] round_shift(input logic signed [PW-1:0] x,
                                                        input int sh);
      logic signed [PW-1:0] bias;
      bias = $signed(PW'(1) << (sh - 1));
      if (x[PW-1]) begin
         bias = bias - $signed(PW'(1));
      end
      return (x + bias) >>> sh;
   endfunction

   // clamp to the symmetric Q2 range
   function automatic logic signed [W:0] sat_wide(input logic signed [PW-1:0] x);
      logic signed [PW-1:0] y;
      y = x;
      if (x > WIDE_HI) begin
         y = WIDE_HI;
      end else if (x < WIDE_LO) begin
         y = WIDE_LO;
      end
      return y[W:0];
   endfunction

   // clamp to the sample range
   function automatic logic signed [W-1:0] sat_smp(input logic signed [PW-1:0] x);
      logic signed [PW-1:0] y;
      y = x;
      if (x > SMP_HI) begin
         y = SMP_HI;
      end else if (x < SMP_LO) begin
         y = SMP_LO;
      end
      return y[W-1:0];
   endfunction

   // multiplier operand select, one product per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_RC: begin
            mul_a = OPW'(re_ff);
            mul_b = OPW'(coef.cos_v);
         end
         ST_IS: begin
            mul_a = OPW'(im_ff);
            mul_b = OPW'(coef.sin_v);
         end
         ST_RS: begin
            mul_a = OPW'(re_ff);
            mul_b = OPW'(coef.sin_v);
         end
         ST_IC: begin
            mul_a = OPW'(im_ff);
            mul_b = OPW'(coef.cos_v);
         end
         ST_RR: begin
            mul_a = OPW'(r_ff);
            mul_b = OPW'(r_ff);
         end
         ST_II: begin
            mul_a = OPW'(i_ff);
            mul_b = OPW'(i_ff);
         end
         ST_FR: begin
            mul_a = OPW'(f_ff);
            mul_b = OPW'(r_ff);
         end
         ST_FI: begin
            mul_a = OPW'(f_ff);
            mul_b = OPW'(i_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // step sequencer: rotate, square, newton factor, rescale
   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      acc_in   = acc_ff;
      r_in     = r_ff;
      i_in     = i_ff;
      f_in     = f_ff;
      re_in    = re_ff;
      im_in    = im_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RC;
            end
         end
         ST_RC: begin
            p_in     = prod;
            state_in = ST_IS;
         end
         ST_IS: begin
            p_in     = prod;
            acc_in   = p_ff;
            state_in = ST_RS;
         end
         ST_RS: begin
            p_in     = prod;
            acc_in   = acc_ff - p_ff;
            state_in = ST_IC;
         end
         ST_IC: begin
            p_in     = prod;
            r_in     = sat_wide(round_shift(acc_ff, COEF_W - 1));
            acc_in   = p_ff;
            state_in = ST_RR;
         end
         ST_RR: begin
            p_in     = prod;
            acc_in   = acc_ff + p_ff;
            state_in = ST_IR;
         end
         ST_IR: begin
            i_in     = sat_wide(round_shift(acc_ff, COEF_W - 1));
            acc_in   = round_shift(p_ff, FS);
            state_in = ST_II;
         end
         ST_II: begin
            p_in     = prod;
            state_in = ST_L;
         end
         ST_L: begin
            acc_in   = acc_ff + round_shift(p_ff, FS);
            state_in = ST_F;
         end
         ST_F: begin
            f_in     = sat_wide(THREE_HALF - (acc_ff >>> 1));
            state_in = ST_FR;
         end
         ST_FR: begin
            p_in     = prod;
            state_in = ST_FI;
         end
         ST_FI: begin
            p_in     = prod;
            re_in    = sat_smp(round_shift(p_ff, FS));
            state_in = ST_WI;
         end
         ST_WI: begin
            im_in    = sat_smp(round_shift(p_ff, FS));
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, phasor and datapath registers
   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      acc_ff <= acc_in;
      r_ff   <= r_in;
      i_ff   <= i_in;
      f_ff   <= f_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         re_ff    <= SMP_HI[W-1:0];
         im_ff    <= '0;
      end else begin
         state_ff <= state_in;
         re_ff    <= re_in;
         im_ff    <= im_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign imag = im_ff;

endmodule

`default_nettype wire

>>> hw/rtl/fqo_merge.sv
`default_nettype none

module fqo_merge
   import fqo_pkg::*;
#(
   parameter int LANES        = 4,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  capture,
   input  wire logic [LANES-1:0][SAMPLE_WIDTH-1:0]    lane_imag,
   input  wire logic                                  rsp_stall,
   output      logic                                  rsp_valid,
   output      logic [OUT_LANES-1:0][OUT_W-1:0]       rsp_data
);

   logic [OUT_LANES-1:0][OUT_W-1:0] q15;
   logic [OUT_LANES-1:0][OUT_W-1:0] data_ff, data_in;
   logic                            valid_ff, valid_in;

   // bring each lane to Q1.15, absent lanes report zero
   for (genvar k = 0; k < OUT_LANES; k++) begin : g_q15
      if (k >= LANES) begin : g_absent
         assign q15[k] = '0;
      end else if (SAMPLE_WIDTH >= OUT_W) begin : g_down
         assign q15[k] = lane_imag[k][SAMPLE_WIDTH-1 -: OUT_W];
      end else begin : g_up
         assign q15[k] = {lane_imag[k], {(OUT_W - SAMPLE_WIDTH){1'b0}}};
      end
   end

   // output register, loaded when a transaction is taken
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (capture) begin
         data_in  = q15;
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire
